// ===== sv/md2_pkg.sv =====
// Shared types and constants for the MD2 digest core.
// Holds the 256-entry substitution table and the sizes of the block,
// the work area and the lane group. No dependencies.
package md2_pkg;

  typedef logic [7:0] byte_t;

  localparam int unsigned BLOCK_BYTES = 16;
  localparam int unsigned WORK_BYTES  = 48;
  localparam int unsigned LANES       = 4;
  localparam int unsigned WORK_WORDS  = WORK_BYTES / LANES;
  localparam int unsigned BLOCK_WORDS = BLOCK_BYTES / LANES;
  localparam int unsigned ROUNDS      = 18;

  typedef logic [LANES-1:0][7:0]       lane_word_t;
  typedef logic [BLOCK_BYTES-1:0][7:0] block_t;
  typedef logic [WORK_BYTES-1:0][7:0]  work_t;

  localparam byte_t SBOX [256] = '{
    8'd41,  8'd46,  8'd67,  8'd201, 8'd162, 8'd216, 8'd124, 8'd1,
    8'd61,  8'd54,  8'd84,  8'd161, 8'd236, 8'd240, 8'd6,   8'd19,
    8'd98,  8'd167, 8'd5,   8'd243, 8'd192, 8'd199, 8'd115, 8'd140,
    8'd152, 8'd147, 8'd43,  8'd217, 8'd188, 8'd76,  8'd130, 8'd202,
    8'd30,  8'd155, 8'd87,  8'd60,  8'd253, 8'd212, 8'd224, 8'd22,
    8'd103, 8'd66,  8'd111, 8'd24,  8'd138, 8'd23,  8'd229, 8'd18,
    8'd190, 8'd78,  8'd196, 8'd214, 8'd218, 8'd158, 8'd222, 8'd73,
    8'd160, 8'd251, 8'd245, 8'd142, 8'd187, 8'd47,  8'd238, 8'd122,
    8'd169, 8'd104, 8'd121, 8'd145, 8'd21,  8'd178, 8'd7,   8'd63,
    8'd148, 8'd194, 8'd16,  8'd137, 8'd11,  8'd34,  8'd95,  8'd33,
    8'd128, 8'd127, 8'd93,  8'd154, 8'd90,  8'd144, 8'd50,  8'd39,
    8'd53,  8'd62,  8'd204, 8'd231, 8'd191, 8'd247, 8'd151, 8'd3,
    8'd255, 8'd25,  8'd48,  8'd179, 8'd72,  8'd165, 8'd181, 8'd209,
    8'd215, 8'd94,  8'd146, 8'd42,  8'd172, 8'd86,  8'd170, 8'd198,
    8'd79,  8'd184, 8'd56,  8'd210, 8'd150, 8'd164, 8'd125, 8'd182,
    8'd118, 8'd252, 8'd107, 8'd226, 8'd156, 8'd116, 8'd4,   8'd241,
    8'd69,  8'd157, 8'd112, 8'd89,  8'd100, 8'd113, 8'd135, 8'd32,
    8'd134, 8'd91,  8'd207, 8'd101, 8'd230, 8'd45,  8'd168, 8'd2,
    8'd27,  8'd96,  8'd37,  8'd173, 8'd174, 8'd176, 8'd185, 8'd246,
    8'd28,  8'd70,  8'd97,  8'd105, 8'd52,  8'd64,  8'd126, 8'd15,
    8'd85,  8'd71,  8'd163, 8'd35,  8'd221, 8'd81,  8'd175, 8'd58,
    8'd195, 8'd92,  8'd249, 8'd206, 8'd186, 8'd197, 8'd234, 8'd38,
    8'd44,  8'd83,  8'd13,  8'd110, 8'd133, 8'd40,  8'd132, 8'd9,
    8'd211, 8'd223, 8'd205, 8'd244, 8'd65,  8'd129, 8'd77,  8'd82,
    8'd106, 8'd220, 8'd55,  8'd200, 8'd108, 8'd193, 8'd171, 8'd250,
    8'd36,  8'd225, 8'd123, 8'd8,   8'd12,  8'd189, 8'd177, 8'd74,
    8'd120, 8'd136, 8'd149, 8'd139, 8'd227, 8'd99,  8'd232, 8'd109,
    8'd233, 8'd203, 8'd213, 8'd254, 8'd59,  8'd0,   8'd29,  8'd57,
    8'd242, 8'd239, 8'd183, 8'd14,  8'd102, 8'd88,  8'd208, 8'd228,
    8'd166, 8'd119, 8'd114, 8'd248, 8'd235, 8'd117, 8'd75,  8'd10,
    8'd49,  8'd68,  8'd80,  8'd180, 8'd143, 8'd237, 8'd31,  8'd26,
    8'd219, 8'd153, 8'd141, 8'd51,  8'd159, 8'd17,  8'd131, 8'd20
  };

endpackage

// ===== sv/md2_sbox_unit.sv =====
// Four-lane chained substitution unit shared by checksum and mixing.
// Depends on md2_pkg for the S table and the lane word type.
module md2_sbox_unit (
  input  md2_pkg::byte_t      chain_in,
  input  md2_pkg::lane_word_t x,
  input  md2_pkg::lane_word_t m,
  output md2_pkg::lane_word_t y,
  output md2_pkg::byte_t      chain_out
);

  // each lane feeds its result forward as the next lane's chain byte
  always_comb begin
    md2_pkg::byte_t c;
    c = chain_in;
    for (int i = 0; i < int'(md2_pkg::LANES); i++) begin
      y[i] = x[i] ^ md2_pkg::SBOX[c ^ m[i]];
      c    = y[i];
    end
    chain_out = c;
  end

endmodule

// ===== sv/md2_message_digest_core.sv =====
// MD2 message digest core: sequencer, block/checksum/hash state and output stage.
// Depends on md2_pkg and md2_sbox_unit.
//
// Send message bytes as beats with tuser = 0, then one beat with tuser = 1 to
// finish; the digest comes out as two 64-bit beats, first digest byte in the
// top bits, tuser = word index, tlast on the second. Other absorb beats leave
// tready high; the sixteenth byte of a block holds it low while the block is
// processed (load, checksum, then mixing). A finish holds tready low through
// the padded block, then the checksum block, then the hand-off of the digest
// to the output register, which waits until the previous digest has drained.
// The work is done by the four-lane chained S-table unit, 12 passes of it per
// round over the 48-byte work area, 18 rounds. The digest waits in its own
// register, so a new message may start while it is still being read out.
module md2_message_digest_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [63:0] digest_word
  output logic        m_axis_tuser,   // [0] word_index
  output logic        m_axis_tlast    // last_word
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CSUM,
    ST_MIX,
    ST_DONE
  } state_t;

  state_t                state;
  logic [3:0]            fill_count;
  md2_pkg::block_t       block_buf;
  md2_pkg::block_t       csum;
  md2_pkg::block_t       hash_st;
  md2_pkg::work_t        work;
  md2_pkg::byte_t        chain;
  logic [4:0]            round;
  logic [3:0]            step;
  logic                  fin;
  logic                  ck_pass;
  md2_pkg::block_t       digest;
  logic                  out_pending;
  logic                  out_idx;

  md2_pkg::lane_word_t   unit_x;
  md2_pkg::lane_word_t   unit_m;
  md2_pkg::lane_word_t   unit_y;
  md2_pkg::byte_t        unit_chain;
  md2_pkg::block_t       load_blk;
  md2_pkg::byte_t        pad;
  logic [63:0]           word0;
  logic [63:0]           word1;

  md2_sbox_unit u_sbox (
    .chain_in  (chain),
    .x         (unit_x),
    .m         (unit_m),
    .y         (unit_y),
    .chain_out (unit_chain)
  );

  always_comb begin
    if (state == ST_CSUM) begin
      unit_x = csum[md2_pkg::LANES-1:0];
      unit_m = block_buf[md2_pkg::LANES-1:0];
    end else begin
      unit_x = work[md2_pkg::LANES-1:0];
      unit_m = '0;
    end
  end

  assign load_blk      = ck_pass ? csum : block_buf;
  assign pad           = 8'(5'd16 - {1'b0, fill_count});
  assign s_axis_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      fill_count  <= '0;
      csum        <= '0;
      hash_st     <= '0;
      chain       <= '0;
      round       <= '0;
      step        <= '0;
      fin         <= 1'b0;
      ck_pass     <= 1'b0;
      out_pending <= 1'b0;
      out_idx     <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        out_idx <= ~out_idx;
        if (out_idx) begin
          out_pending <= 1'b0;
        end
      end

      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            if (!s_axis_tuser) begin
              block_buf[fill_count] <= s_axis_tdata;
              fill_count            <= fill_count + 4'd1;
              if (fill_count == 4'(md2_pkg::BLOCK_BYTES - 1)) begin
                state <= ST_LOAD;
              end
            end else begin
              // pad the tail with N bytes of value N
              for (int k = 0; k < int'(md2_pkg::BLOCK_BYTES); k++) begin
                if (k >= int'(fill_count)) begin
                  block_buf[k] <= pad;
                end
              end
              fill_count <= '0;
              fin        <= 1'b1;
              state      <= ST_LOAD;
            end
          end
        end

        ST_LOAD: begin
          work  <= {hash_st ^ load_blk, load_blk, hash_st};
          chain <= ck_pass ? 8'd0 : csum[md2_pkg::BLOCK_BYTES-1];
          round <= '0;
          step  <= '0;
          state <= ck_pass ? ST_MIX : ST_CSUM;
        end

        ST_CSUM: begin
          csum      <= {unit_y, csum[md2_pkg::BLOCK_BYTES-1:md2_pkg::LANES]};
          block_buf <= {block_buf[md2_pkg::LANES-1:0],
                        block_buf[md2_pkg::BLOCK_BYTES-1:md2_pkg::LANES]};
          if (step == 4'(md2_pkg::BLOCK_WORDS - 1)) begin
            chain <= '0;
            step  <= '0;
            state <= ST_MIX;
          end else begin
            chain <= unit_chain;
            step  <= step + 4'd1;
          end
        end

        ST_MIX: begin
          work <= {unit_y, work[md2_pkg::WORK_BYTES-1:md2_pkg::LANES]};
          if (step == 4'(md2_pkg::WORK_WORDS - 1)) begin
            step  <= '0;
            chain <= unit_chain + {3'b000, round};
            round <= round + 5'd1;
            if (round == 5'(md2_pkg::ROUNDS - 1)) begin
              // rotation is back in place: bytes 0..15 of the next work area
              hash_st <= work[md2_pkg::BLOCK_BYTES+md2_pkg::LANES-1:md2_pkg::LANES];
              if (ck_pass) begin
                state <= ST_DONE;
              end else if (fin) begin
                ck_pass <= 1'b1;
                state   <= ST_LOAD;
              end else begin
                state <= ST_IDLE;
              end
            end
          end else begin
            chain <= unit_chain;
            step  <= step + 4'd1;
          end
        end

        ST_DONE: begin
          // hold until the previous digest has fully drained
          if (!out_pending) begin
            digest      <= hash_st;
            out_pending <= 1'b1;
            out_idx     <= 1'b0;
            hash_st     <= '0;
            csum        <= '0;
            fin         <= 1'b0;
            ck_pass     <= 1'b0;
            state       <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      word0[8*(7-k) +: 8] = digest[k];
      word1[8*(7-k) +: 8] = digest[8+k];
    end
  end

  assign m_axis_tvalid = out_pending;
  assign m_axis_tdata  = out_idx ? word1 : word0;
  assign m_axis_tuser  = out_idx;
  assign m_axis_tlast  = out_idx;

`ifndef NO_ASSERTIONS
  a_mix_step_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_MIX |-> step < 4'(md2_pkg::WORK_WORDS))
    else $error("mixing step counter out of range");

  a_ck_needs_fin: assert property (@(posedge clk) disable iff (rst)
    ck_pass |-> fin)
    else $error("checksum block pass without a finish in progress");

  a_fill_clear_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> fill_count == 4'd0)
    else $error("fill count nonzero while a block is processed");

  a_handoff: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && !out_pending) |=> (out_pending && !out_idx && state == ST_IDLE))
    else $error("digest handoff to output stage failed");
`endif

endmodule

// ===== verif/md2_digest_checker.sv =====
// Command codes shared by the testbench and a checker that predicts MD2
// digests from the input beats and compares them with the output beats.
// Depends on md2_pkg for the byte type, the S table and the block sizes.
package md2_tb_pkg;

  typedef enum logic {
    CMD_ABSORB = 1'b0,
    CMD_FINISH = 1'b1
  } md2_cmd_t;

endpackage

module md2_digest_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] cmd
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,   // [63:0] digest_word
  input  logic        m_axis_tuser,   // [0] word_index
  input  logic        m_axis_tlast,
  output int          mismatches,
  output int          pending,
  output int          words_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [63:0] word;
    logic        index;
    logic        last;
  } digest_beat_t;

  digest_beat_t expected_words[$];

  md2_pkg::byte_t msg_block    [md2_pkg::BLOCK_BYTES];
  int unsigned    msg_fill;
  md2_pkg::byte_t run_checksum [md2_pkg::BLOCK_BYTES];
  md2_pkg::byte_t digest_state [md2_pkg::BLOCK_BYTES];

  // 18 rounds over the 48-byte work area, result folded into digest_state
  function automatic void compress_into_state(
      input md2_pkg::byte_t blk [md2_pkg::BLOCK_BYTES]);
    md2_pkg::byte_t work [md2_pkg::WORK_BYTES];
    md2_pkg::byte_t chain;
    chain = '0;
    for (int k = 0; k < md2_pkg::BLOCK_BYTES; k++) begin
      work[k]                          = digest_state[k];
      work[md2_pkg::BLOCK_BYTES + k]   = blk[k];
      work[2*md2_pkg::BLOCK_BYTES + k] = blk[k] ^ digest_state[k];
    end
    for (int r = 0; r < md2_pkg::ROUNDS; r++) begin
      for (int k = 0; k < md2_pkg::WORK_BYTES; k++) begin
        work[k] = work[k] ^ md2_pkg::SBOX[chain];
        chain   = work[k];
      end
      chain = chain + 8'(r);
    end
    for (int k = 0; k < md2_pkg::BLOCK_BYTES; k++) digest_state[k] = work[k];
  endfunction

  function automatic void fold_block();
    md2_pkg::byte_t prev;
    prev = run_checksum[md2_pkg::BLOCK_BYTES-1];
    for (int k = 0; k < md2_pkg::BLOCK_BYTES; k++) begin
      run_checksum[k] = run_checksum[k] ^ md2_pkg::SBOX[msg_block[k] ^ prev];
      prev            = run_checksum[k];
    end
    compress_into_state(msg_block);
  endfunction

  function automatic void clear_message();
    msg_fill = 0;
    for (int k = 0; k < md2_pkg::BLOCK_BYTES; k++) begin
      msg_block[k]    = '0;
      run_checksum[k] = '0;
      digest_state[k] = '0;
    end
  endfunction

  function automatic void predict_digest();
    md2_pkg::byte_t pad;
    md2_pkg::byte_t check_blk [md2_pkg::BLOCK_BYTES];
    digest_beat_t   beat;
    pad = md2_pkg::byte_t'(md2_pkg::BLOCK_BYTES - msg_fill);
    for (int k = msg_fill; k < md2_pkg::BLOCK_BYTES; k++) msg_block[k] = pad;
    fold_block();
    check_blk = run_checksum;
    compress_into_state(check_blk);
    for (int w = 0; w < 2; w++) begin
      beat.word = '0;
      for (int k = 0; k < 8; k++) beat.word = {beat.word[55:0], digest_state[w*8 + k]};
      beat.index = (w == 1);
      beat.last  = (w == 1);
      expected_words.push_back(beat);
    end
    clear_message();
  endfunction

  function automatic void check_beat();
    digest_beat_t want;
    if (expected_words.size() == 0) begin
      $display("%0t: digest beat %h arrived with none expected", $time, m_axis_tdata);
      mismatches++;
      return;
    end
    want = expected_words.pop_front();
    words_checked++;
    if (m_axis_tdata !== want.word) begin
      $display("%0t: digest word mismatch: expected %h, actual %h",
               $time, want.word, m_axis_tdata);
      mismatches++;
    end
    if (m_axis_tuser !== want.index) begin
      $display("%0t: word index mismatch: expected %0d, actual %0d",
               $time, want.index, m_axis_tuser);
      mismatches++;
    end
    if (m_axis_tlast !== want.last) begin
      $display("%0t: last flag mismatch: expected %0d, actual %0d",
               $time, want.last, m_axis_tlast);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_message();
      expected_words.delete();
      mismatches    = 0;
      words_checked = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (md2_tb_pkg::md2_cmd_t'(s_axis_tuser) == md2_tb_pkg::CMD_FINISH) begin
          predict_digest();
        end else begin
          msg_block[msg_fill] = s_axis_tdata;
          msg_fill++;
          if (msg_fill == md2_pkg::BLOCK_BYTES) begin
            fold_block();
            msg_fill = 0;
          end
        end
      end
      if (m_axis_tvalid && m_axis_tready) check_beat();
    end
    pending = expected_words.size();
  end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the MD2 digest core: clock, reset, message stimulus,
// random backpressure and the verdict. Depends on md2_pkg, md2_tb_pkg and
// md2_digest_checker, which does the prediction and comparison.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET  = 1350;
  localparam int MAX_GAP      = 12;
  localparam int HOLD_CYCLES  = 4000;
  localparam int STALL_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 600;

  typedef enum int {FILL_RANDOM, FILL_ZEROS, FILL_ONES, FILL_REPEAT} fill_kind_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = md2_tb_pkg::CMD_ABSORB;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  int mismatches;
  int pending;
  int words_checked;
  int items_sent = 0;
  int bytes_sent = 0;
  int msgs_sent  = 0;
  int idle_cycles = 0;
  bit send_no_idle = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  md2_message_digest_core dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  md2_digest_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .mismatches   (mismatches),
    .pending      (pending),
    .words_checked(words_checked)
  );

  // end the run if neither side moves a beat for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // digest side: random stalls, plus one long hold-off to fill the core up
  initial begin
    int gap;
    int beats;
    bit held;
    bit no_idle;
    beats   = 0;
    held    = 1'b0;
    no_idle = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (beats % 8 == 0) no_idle = ($urandom_range(0, 3) == 0);
      gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (beats == 6 && !held) begin
        gap  = HOLD_CYCLES;
        held = 1'b1;
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      beats++;
    end
  end

  task automatic send_beat(input md2_tb_pkg::md2_cmd_t cmd, input md2_pkg::byte_t data);
    int gap;
    gap = send_no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= cmd;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic send_message(input int len, input fill_kind_t fill);
    md2_pkg::byte_t fixed;
    md2_pkg::byte_t b;
    fixed = md2_pkg::byte_t'($urandom_range(0, 255));
    for (int i = 0; i < len; i++) begin
      case (fill)
        FILL_ZEROS:  b = 8'h00;
        FILL_ONES:   b = 8'hFF;
        FILL_REPEAT: b = fixed;
        default:     b = md2_pkg::byte_t'($urandom_range(0, 255));
      endcase
      send_beat(md2_tb_pkg::CMD_ABSORB, b);
      bytes_sent++;
    end
    // the byte on a finish beat must be ignored, so make it random
    send_beat(md2_tb_pkg::CMD_FINISH, md2_pkg::byte_t'($urandom_range(0, 255)));
    msgs_sent++;
  endtask

  initial begin
    int         boundary_lens [7];
    int         len;
    int         pick;
    fill_kind_t fill;
    boundary_lens = '{15, 16, 17, 31, 32, 33, 48};

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // empty message: a whole block of padding
    send_message(0, FILL_RANDOM);
    // both byte extremes, padding of fourteen
    send_beat(md2_tb_pkg::CMD_ABSORB, 8'h00);
    send_beat(md2_tb_pkg::CMD_ABSORB, 8'hFF);
    bytes_sent += 2;
    send_beat(md2_tb_pkg::CMD_FINISH, 8'hFF);
    msgs_sent++;
    // fifteen bytes: a single byte of padding
    for (int k = 0; k < 15; k++) begin
      send_beat(md2_tb_pkg::CMD_ABSORB, md2_pkg::byte_t'(k * 17));
      bytes_sent++;
    end
    send_beat(md2_tb_pkg::CMD_FINISH, 8'h00);
    msgs_sent++;

    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 9);
      if (pick < 6)      len = $urandom_range(0, 40);
      else if (pick < 8) len = boundary_lens[$urandom_range(0, 6)];
      else               len = $urandom_range(41, 96);
      fill = ($urandom_range(0, 9) < 7) ? FILL_RANDOM : fill_kind_t'($urandom_range(1, 3));
      send_no_idle = ($urandom_range(0, 3) == 0);
      send_message(len, fill);
    end
    s_axis_tvalid <= 1'b0;

    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d beats: %0d messages with %0d bytes, lengths 0 to 96.",
             items_sent, msgs_sent, bytes_sent);
    $display("Checked %0d digest words under random stalls and one long hold-off.",
             words_checked);
    if (mismatches == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/md2_pkg.sv
sv/md2_sbox_unit.sv
sv/md2_message_digest_core.sv
verif/md2_digest_checker.sv
verif/tb.sv
